// ===== design/rts_pkg.sv =====
package rts_pkg;

    localparam int NUM_RADIALS = 360;
    localparam int MAX_BINS = 256;
    localparam int MAX_HALF_WINDOW = 7;
    localparam int DEPTH = NUM_RADIALS * MAX_BINS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int RAD_W = 9;
    localparam int BIN_W = 8;
    localparam int GATE_W = 9;

    localparam logic [2:0] REG_SPIN_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_AZ_HALF = 3'd1;
    localparam logic [2:0] REG_RNG_HALF = 3'd2;
    localparam logic [2:0] REG_GATES = 3'd3;
    localparam logic [2:0] REG_AZ_WRAP = 3'd4;
    localparam logic [2:0] REG_FOLDED = 3'd5;
    localparam logic [2:0] REG_MISSING = 3'd6;

    localparam logic [1:0] ST_VALID = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;
    localparam logic [1:0] ST_OUTSIDE = 2'd3;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CENTER,
        S_CHECK,
        S_ROW,
        S_RD0,
        S_RD1,
        S_ACC,
        S_DIV_START,
        S_DIV,
        S_OUT
    } state_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

endpackage

// ===== design/reflectivity_texture_sign_spin_core.sv =====
// A load is accepted whenever no query is in progress.
// A query outside the region or with a missing center goes from the check straight to the output state.
// Otherwise it reads the bin pairs of each radial in the window and, when valid differences exist,
// runs three 32-step divisions for texture, mean sign and spin percent before the output state.
// One request is in progress at a time; a finished result waits in an output register.
// Synchronous active-low reset restores register defaults; the store is not cleared.
module reflectivity_texture_sign_spin_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] command, [9:1] radial_index, [17:10] bin_index, [25:18] refl_code, zero fill
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [17:0] texture, [27:18] mean_sign, [38:28] spin_percent, [40:39] status, zero fill
    output logic [47:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    logic [7:0] mem [rts_pkg::DEPTH];
    logic [7:0] rd_reg;

    logic [7:0] thr_reg, fold_reg, miss_reg;
    logic [2:0] da_reg, dr_reg;
    logic [8:0] gates_reg;
    logic       wrap_reg;

    rts_pkg::state_t state_reg, state_next;
    logic [8:0]  rad_reg, row_reg;
    logic [7:0]  bin_reg, k_reg, z0_reg;
    logic [3:0]  a_cnt_reg;
    logic [7:0]  count_reg;
    logic [7:0]  spins_reg;
    logic [23:0] sumsq_reg;
    logic signed [9:0] sumsign_reg;
    logic        have_prev_reg;
    logic signed [1:0] prev_reg;
    logic [1:0]  div_sel_reg;
    logic [17:0] tex_reg;
    logic [9:0]  ms_reg;
    logic [10:0] sp_reg;
    logic [1:0]  st_reg;
    logic        mvalid_reg;
    logic [40:0] out_reg;

    logic [8:0]  g_eff;
    logic [8:0]  bin_lo;
    logic [8:0]  bin_hi;
    logic        load_fire, query_fire;
    logic        out_free;
    logic [rts_pkg::ADDR_W-1:0] rd_addr;
    logic        rd_en;
    logic [7:0]  z1;
    logic signed [8:0] d;
    logic [7:0]  mag;
    logic [15:0] mag_sq;
    logic signed [1:0] sgn;
    logic        pair_ok;
    logic        spin_hit;
    logic        neg_ms;
    logic [9:0]  abs_ss;
    rts_pkg::div_req_t dreq;
    rts_pkg::div_rsp_t drsp;

    assign g_eff = (gates_reg > 9'(rts_pkg::MAX_BINS)) ? 9'(rts_pkg::MAX_BINS) : gates_reg;
    assign bin_lo = {1'b0, bin_reg} - {6'd0, dr_reg};
    assign bin_hi = {1'b0, bin_reg} + {6'd0, dr_reg};

    assign s_tready = (state_reg == rts_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign load_fire = s_tvalid && s_tready && (s_tdata[0] == rts_pkg::CMD_LOAD);
    assign query_fire = s_tvalid && s_tready && (s_tdata[0] == rts_pkg::CMD_QUERY);
    assign out_free = !mvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= 8'd6;
            da_reg <= 3'd2;
            dr_reg <= 3'd2;
            gates_reg <= 9'd230;
            wrap_reg <= 1'b1;
            fold_reg <= 8'd1;
            miss_reg <= 8'd0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                rts_pkg::REG_SPIN_THRESHOLD: thr_reg <= cfg_data[7:0];
                rts_pkg::REG_AZ_HALF:        da_reg <= cfg_data[2:0];
                rts_pkg::REG_RNG_HALF:       dr_reg <= cfg_data[2:0];
                rts_pkg::REG_GATES:          gates_reg <= cfg_data;
                rts_pkg::REG_AZ_WRAP:        wrap_reg <= cfg_data[0];
                rts_pkg::REG_FOLDED:         fold_reg <= cfg_data[7:0];
                rts_pkg::REG_MISSING:        miss_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        rd_en = 1'b0;
        rd_addr = {row_reg[rts_pkg::ADDR_W-9:0], k_reg};
        unique case (state_reg)
            rts_pkg::S_CENTER: begin
                rd_en = 1'b1;
                rd_addr = {rad_reg[rts_pkg::ADDR_W-9:0], bin_reg};
            end
            rts_pkg::S_RD0: rd_en = 1'b1;
            rts_pkg::S_RD1: begin
                rd_en = 1'b1;
                rd_addr = {row_reg[rts_pkg::ADDR_W-9:0], k_reg + 8'd1};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (load_fire && s_tdata[9:1] < 9'(rts_pkg::NUM_RADIALS)) begin
            mem[{s_tdata[9-(17-rts_pkg::ADDR_W):1], s_tdata[17:10]}] <= s_tdata[25:18];
        end
        if (rd_en) begin
            rd_reg <= mem[rd_addr];
        end
    end

    assign z1 = rd_reg;
    assign d = $signed({1'b0, z1}) - $signed({1'b0, z0_reg});
    assign mag = d[8] ? 8'(-d) : d[7:0];
    assign mag_sq = {8'd0, mag} * {8'd0, mag};
    assign sgn = d[8] ? -2'sd1 : ((d == 9'sd0) ? 2'sd0 : 2'sd1);
    assign pair_ok = ({1'b0, k_reg} + 9'd1 < g_eff) && (z0_reg > fold_reg) && (z1 > fold_reg);
    assign spin_hit = mag > thr_reg && sgn != (have_prev_reg ? prev_reg : sgn);
    assign neg_ms = sumsign_reg[9];
    assign abs_ss = neg_ms ? 10'(-sumsign_reg) : sumsign_reg;

    always_comb begin
        dreq.start = 1'b0;
        unique case (div_sel_reg)
            2'd0: dreq.dividend = {6'd0, sumsq_reg, 2'd0};
            2'd1: dreq.dividend = {14'd0, abs_ss, 8'd0};
            default: dreq.dividend = 32'(spins_reg) * 32'd1600;
        endcase
        dreq.divisor = {24'd0, count_reg};
        if (state_reg == rts_pkg::S_DIV_START) begin
            dreq.start = 1'b1;
        end
    end

    rts_divider u_div (
        .aclk(aclk),
        .aresetn(aresetn),
        .req(dreq),
        .rsp(drsp)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rts_pkg::S_IDLE:   if (query_fire) state_next = rts_pkg::S_CENTER;
            rts_pkg::S_CENTER: state_next = rts_pkg::S_CHECK;
            rts_pkg::S_CHECK: begin
                if (rad_reg >= 9'(rts_pkg::NUM_RADIALS) || {1'b0, bin_reg} < {6'd0, dr_reg}
                    || bin_hi >= g_eff || (!wrap_reg && (rad_reg < {6'd0, da_reg}
                    || rad_reg + {6'd0, da_reg} > 9'(rts_pkg::NUM_RADIALS - 1))))
                    state_next = rts_pkg::S_OUT;
                else if (rd_reg == miss_reg)
                    state_next = rts_pkg::S_OUT;
                else
                    state_next = rts_pkg::S_RD0;
            end
            rts_pkg::S_ROW:  state_next = rts_pkg::S_RD0;
            rts_pkg::S_RD0:  state_next = rts_pkg::S_RD1;
            rts_pkg::S_RD1:  state_next = rts_pkg::S_ACC;
            rts_pkg::S_ACC: begin
                if ({1'b0, k_reg} < bin_hi) state_next = rts_pkg::S_RD0;
                else if (a_cnt_reg != 4'd0) state_next = rts_pkg::S_ROW;
                else if (count_reg == 8'd0 && !pair_ok) state_next = rts_pkg::S_OUT;
                else state_next = rts_pkg::S_DIV_START;
            end
            rts_pkg::S_DIV_START: state_next = rts_pkg::S_DIV;
            rts_pkg::S_DIV: begin
                if (drsp.done)
                    state_next = (div_sel_reg == 2'd2) ? rts_pkg::S_OUT
                                                       : rts_pkg::S_DIV_START;
            end
            rts_pkg::S_OUT:  if (out_free) state_next = rts_pkg::S_IDLE;
            default: state_next = rts_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rts_pkg::S_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_tvalid && m_tready) mvalid_reg <= 1'b0;
            if (state_reg == rts_pkg::S_OUT && out_free) mvalid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            rts_pkg::S_IDLE: begin
                rad_reg <= s_tdata[9:1];
                bin_reg <= s_tdata[17:10];
            end
            rts_pkg::S_CHECK: begin
                tex_reg <= '0;
                ms_reg <= '0;
                sp_reg <= '0;
                st_reg <= (rd_reg == miss_reg) ? rts_pkg::ST_MISSING : rts_pkg::ST_OUTSIDE;
                if (rad_reg >= 9'(rts_pkg::NUM_RADIALS) || {1'b0, bin_reg} < {6'd0, dr_reg}
                    || bin_hi >= g_eff || (!wrap_reg && (rad_reg < {6'd0, da_reg}
                    || rad_reg + {6'd0, da_reg} > 9'(rts_pkg::NUM_RADIALS - 1))))
                    st_reg <= rts_pkg::ST_OUTSIDE;
                a_cnt_reg <= {da_reg, 1'b0};
                row_reg <= (rad_reg < {6'd0, da_reg})
                    ? rad_reg + 9'(rts_pkg::NUM_RADIALS) - {6'd0, da_reg}
                    : rad_reg - {6'd0, da_reg};
                k_reg <= bin_lo[7:0];
                count_reg <= '0;
                spins_reg <= '0;
                sumsq_reg <= '0;
                sumsign_reg <= '0;
                have_prev_reg <= 1'b0;
                div_sel_reg <= 2'd0;
            end
            rts_pkg::S_ROW: begin
                row_reg <= (row_reg == 9'(rts_pkg::NUM_RADIALS - 1)) ? 9'd0 : row_reg + 9'd1;
                a_cnt_reg <= a_cnt_reg - 4'd1;
                k_reg <= bin_lo[7:0];
                have_prev_reg <= 1'b0;
            end
            rts_pkg::S_RD1: z0_reg <= rd_reg;
            rts_pkg::S_ACC: begin
                if (pair_ok) begin
                    count_reg <= count_reg + 8'd1;
                    sumsq_reg <= sumsq_reg + {8'd0, mag_sq};
                    sumsign_reg <= sumsign_reg + 10'(sgn);
                    if (!have_prev_reg) begin
                        have_prev_reg <= 1'b1;
                        prev_reg <= sgn;
                    end
                    if (spin_hit) begin
                        spins_reg <= spins_reg + 8'd1;
                        prev_reg <= sgn;
                    end
                end
                if ({1'b0, k_reg} < bin_hi) k_reg <= k_reg + 8'd1;
                st_reg <= rts_pkg::ST_EMPTY;
            end
            rts_pkg::S_DIV: begin
                if (drsp.done) begin
                    st_reg <= rts_pkg::ST_VALID;
                    div_sel_reg <= div_sel_reg + 2'd1;
                    unique case (div_sel_reg)
                        2'd0: tex_reg <= drsp.quotient[17:0];
                        2'd1: ms_reg <= neg_ms ? 10'(-drsp.quotient[9:0])
                                               : drsp.quotient[9:0];
                        default: sp_reg <= drsp.quotient[10:0];
                    endcase
                end
            end
            rts_pkg::S_OUT: begin
                if (out_free) out_reg <= {st_reg, sp_reg, ms_reg, tex_reg};
            end
            default: ;
        endcase
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata = {7'd0, out_reg};

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != rts_pkg::S_IDLE) |-> !s_tready) else $error("accept while busy");
    a_out_from_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == rts_pkg::S_OUT)) else $error("bad result");
    a_valid_has_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rts_pkg::S_DIV_START) |-> count_reg != 8'd0)
        else $error("valid status without differences");
`endif

endmodule

// ===== design/rts_divider.sv =====
module rts_divider (
    input  logic               aclk,
    input  logic               aresetn,
    input  rts_pkg::div_req_t  req,
    output rts_pkg::div_rsp_t  rsp
);

    logic [31:0] quo_reg;
    logic [31:0] rem_reg;
    logic [31:0] den_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] trial;

    assign trial = {rem_reg, quo_reg[31]} - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg <= 6'd32;
                quo_reg <= req.dividend;
                rem_reg <= '0;
                den_reg <= req.divisor;
            end else if (busy_reg) begin
                if (!trial[32]) begin
                    rem_reg <= trial[31:0];
                    quo_reg <= {quo_reg[30:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[30:0], quo_reg[31]};
                    quo_reg <= {quo_reg[30:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== sim/reflectivity_texture_sign_spin_core_tb.sv =====
`timescale 1ns / 100ps

typedef struct packed {
    logic [1:0]  status;
    logic [10:0] spin_percent;
    logic [9:0]  mean_sign;
    logic [17:0] texture;
} texture_result_t;

class texture_scoreboard;
    byte unsigned    refl[rts_pkg::NUM_RADIALS * rts_pkg::MAX_BINS];
    bit              written[rts_pkg::NUM_RADIALS * rts_pkg::MAX_BINS];
    int unsigned     spin_thr, az_half, rng_half, gates, az_wrap, folded, missing;
    texture_result_t expected_q[$];
    int              mismatches, loads, queries;
    int              status_seen[4];

    function new();
        spin_thr = 6;
        az_half = 2;
        rng_half = 2;
        gates = 230;
        az_wrap = 1;
        folded = 1;
        missing = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [8:0] val);
        case (idx)
            rts_pkg::REG_SPIN_THRESHOLD: spin_thr = val[7:0];
            rts_pkg::REG_AZ_HALF:        az_half = val[2:0];
            rts_pkg::REG_RNG_HALF:       rng_half = val[2:0];
            rts_pkg::REG_GATES:          gates = val;
            rts_pkg::REG_AZ_WRAP:        az_wrap = val[0];
            rts_pkg::REG_FOLDED:         folded = val[7:0];
            rts_pkg::REG_MISSING:        missing = val[7:0];
            default: ;
        endcase
    endfunction

    function int eff_gates();
        return (gates > rts_pkg::MAX_BINS) ? rts_pkg::MAX_BINS : gates;
    endfunction

    function bit in_region(int rad, int bin);
        if (rad >= rts_pkg::NUM_RADIALS || bin < rng_half || bin + rng_half >= eff_gates())
            return 0;
        if (az_wrap == 0 && (rad < az_half || rad + az_half > rts_pkg::NUM_RADIALS - 1))
            return 0;
        return 1;
    endfunction

    function texture_result_t predict_texture(int rad, int bin);
        texture_result_t r;
        int g, row, z0, z1, d, s, mag, prev, sumsign;
        int unsigned cnt, spins, sumsq;
        bit have_prev;
        r = '0;
        g = eff_gates();
        cnt = 0;
        spins = 0;
        sumsq = 0;
        sumsign = 0;
        if (!in_region(rad, bin)) begin
            r.status = rts_pkg::ST_OUTSIDE;
            return r;
        end
        if (refl[rad * rts_pkg::MAX_BINS + bin] == missing) begin
            r.status = rts_pkg::ST_MISSING;
            return r;
        end
        for (int a = -int'(az_half); a <= int'(az_half); a++) begin
            row = (rad + a + rts_pkg::NUM_RADIALS) % rts_pkg::NUM_RADIALS;
            prev = 0;
            have_prev = 0;
            for (int k = bin - int'(rng_half); k <= bin + int'(rng_half); k++) begin
                if (k + 1 >= g) continue;
                z0 = refl[row * rts_pkg::MAX_BINS + k];
                z1 = refl[row * rts_pkg::MAX_BINS + k + 1];
                if (z0 <= folded || z1 <= folded) continue;
                d = z1 - z0;
                s = (d > 0) ? 1 : ((d < 0) ? -1 : 0);
                mag = (d < 0) ? -d : d;
                cnt++;
                sumsq += mag * mag;
                sumsign += s;
                if (!have_prev) begin
                    prev = s;
                    have_prev = 1;
                end
                if (mag > spin_thr && s != prev) begin
                    spins++;
                    prev = s;
                end
            end
        end
        if (cnt == 0) begin
            r.status = rts_pkg::ST_EMPTY;
            return r;
        end
        r.texture = (sumsq * 4) / cnt;
        r.mean_sign = (sumsign * 256) / int'(cnt);
        r.spin_percent = (spins * 1600) / cnt;
        r.status = rts_pkg::ST_VALID;
        return r;
    endfunction

    function void note_request(logic cmd, int rad, int bin, int code);
        if (cmd == rts_pkg::CMD_LOAD) begin
            if (rad < rts_pkg::NUM_RADIALS && bin < rts_pkg::MAX_BINS) begin
                refl[rad * rts_pkg::MAX_BINS + bin] = code;
                written[rad * rts_pkg::MAX_BINS + bin] = 1;
                loads++;
            end
        end else begin
            expected_q.push_back(predict_texture(rad, bin));
            queries++;
        end
    endfunction

    function void check_result(logic [47:0] data);
        texture_result_t got, exp_r;
        got = data[40:0];
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result %h", data);
            return;
        end
        exp_r = expected_q.pop_front();
        status_seen[exp_r.status]++;
        if (got != exp_r || data[47:41] != 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"mismatch: expected tex %0d sign %0d spin %0d st %0d,",
                          " got tex %0d sign %0d spin %0d st %0d"},
                         exp_r.texture, $signed(exp_r.mean_sign), exp_r.spin_percent,
                         exp_r.status, got.texture, $signed(got.mean_sign),
                         got.spin_percent, got.status);
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module reflectivity_texture_sign_spin_core_tb;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [8:0]  cfg_data;

    texture_scoreboard sb;
    int  requests_sent;
    int  settings_used;
    bit  quiet;

    reflectivity_texture_sign_spin_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #60000000;
        $display("status: fail");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (hold == 0) begin
                if (quiet || $urandom_range(0, 99) < 60) begin
                    m_tready <= 1;
                    hold = $urandom_range(1, 40);
                end else begin
                    m_tready <= 0;
                    hold = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                       : $urandom_range(1, 3);
                end
            end
            hold--;
        end
    end

    task automatic send(logic cmd, int rad, int bin, int code);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {6'b0, code[7:0], bin[7:0], rad[8:0], cmd};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(cmd, rad[8:0], bin[7:0], code[7:0]);
        if (cmd == rts_pkg::CMD_QUERY || rad < rts_pkg::NUM_RADIALS) requests_sent++;
    endtask

    task automatic cfg_write(logic [2:0] idx, int val, bit last);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val[8:0];
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, val[8:0]);
        if (last) cfg_valid <= 0;
    endtask

    task automatic configure(int thr, int az, int rng, int gates, int wrap, int fold,
                             int miss);
        s_tvalid <= 0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (1000) @(posedge aclk);
        cfg_write(rts_pkg::REG_SPIN_THRESHOLD, thr, 0);
        cfg_write(rts_pkg::REG_AZ_HALF, az, 0);
        cfg_write(rts_pkg::REG_RNG_HALF, rng, 0);
        cfg_write(rts_pkg::REG_GATES, gates, 0);
        cfg_write(rts_pkg::REG_AZ_WRAP, wrap, 0);
        cfg_write(rts_pkg::REG_FOLDED, fold, 0);
        cfg_write(rts_pkg::REG_MISSING, miss, 1);
        settings_used++;
    endtask

    function automatic int code_for(int style, int bin, int base);
        int c;
        case (style)
            0: c = $urandom_range(0, 255);
            1: c = base + $urandom_range(0, 6) - 3;
            2: c = base + ((bin % 2) ? 30 : -30) + $urandom_range(0, 20) - 10;
            default: c = $urandom_range(0, sb.folded);
        endcase
        if (c < 0) c = 0;
        if (c > 255) c = 255;
        return c;
    endfunction

    task automatic fill_window(int rad, int bin, int style, int refresh);
        int g, row, base, lo, hi;
        if (!sb.in_region(rad, bin)) return;
        g = sb.eff_gates();
        base = $urandom_range(20, 230);
        lo = bin - int'(sb.rng_half);
        hi = bin + int'(sb.rng_half) + 1;
        for (int a = -int'(sb.az_half); a <= int'(sb.az_half); a++) begin
            row = (rad + a + rts_pkg::NUM_RADIALS) % rts_pkg::NUM_RADIALS;
            for (int e = lo; e <= hi && e < g; e++) begin
                if (!sb.written[row * rts_pkg::MAX_BINS + e] || $urandom_range(0, 99) < refresh)
                    send(rts_pkg::CMD_LOAD, row, e, code_for(style, e, base));
            end
        end
    endtask

    task automatic random_request();
        int r, rad, bin, g, dr, da, style;
        r = $urandom_range(0, 99);
        g = sb.eff_gates();
        dr = sb.rng_half;
        da = sb.az_half;
        style = ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2);
        if (r < 70 && g - 1 - dr >= dr) begin
            if (sb.az_wrap) begin
                rad = $urandom_range(0, 359);
                if ($urandom_range(0, 9) == 0) rad = $urandom_range(0, 1) ? 359 : 0;
            end else begin
                rad = $urandom_range(da, 359 - da);
            end
            bin = $urandom_range(dr, g - 1 - dr);
            fill_window(rad, bin, style, $urandom_range(0, 60));
            if ($urandom_range(0, 9) == 0) send(rts_pkg::CMD_LOAD, rad, bin, sb.missing);
            send(rts_pkg::CMD_QUERY, rad, bin, $urandom_range(0, 255));
        end else if (r < 82) begin
            send(rts_pkg::CMD_LOAD, $urandom_range(0, 511), $urandom_range(0, 255),
                 $urandom_range(0, 255));
        end else begin
            rad = $urandom_range(0, 511);
            bin = $urandom_range(0, 255);
            fill_window(rad, bin, style, 0);
            send(rts_pkg::CMD_QUERY, rad, bin, $urandom_range(0, 255));
        end
    endtask

    task automatic run_phase(int budget);
        int start;
        start = requests_sent;
        quiet = ($urandom_range(0, 3) == 0);
        while (requests_sent - start < budget) random_request();
        quiet = 0;
    endtask

    initial begin
        sb = new();
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        m_tready = 0;
        cfg_valid = 0;
        cfg_index = rts_pkg::REG_SPIN_THRESHOLD;
        cfg_data = '0;
        requests_sent = 0;
        settings_used = 1;
        quiet = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        send(rts_pkg::CMD_LOAD, 511, 255, 255);
        send(rts_pkg::CMD_QUERY, 511, 100, 0);
        send(rts_pkg::CMD_QUERY, 359, 1, 0);
        send(rts_pkg::CMD_QUERY, 10, 227, 0);
        fill_window(0, 2, 0, 100);
        send(rts_pkg::CMD_QUERY, 0, 2, 0);
        fill_window(359, 227 - 3, 2, 100);
        send(rts_pkg::CMD_QUERY, 359, 224, 0);
        fill_window(100, 50, 1, 100);
        send(rts_pkg::CMD_LOAD, 100, 50, 0);
        send(rts_pkg::CMD_QUERY, 100, 50, 0);
        fill_window(200, 120, 3, 100);
        send(rts_pkg::CMD_LOAD, 200, 120, 1);
        send(rts_pkg::CMD_QUERY, 200, 120, 0);
        fill_window(201, 121, 2, 100);
        send(rts_pkg::CMD_QUERY, 201, 121, 0);
        fill_window(180, 227 - 1, 1, 100);
        send(rts_pkg::CMD_QUERY, 180, 227 - 1, 255);
        run_phase(150);

        configure(0, 0, 0, 2, 0, 0, 255);
        send(rts_pkg::CMD_QUERY, 0, 0, 0);
        send(rts_pkg::CMD_QUERY, 359, 1, 0);
        run_phase(100);
        configure(255, 7, 7, 256, 1, 255, 0);
        run_phase(40);
        configure(0, 7, 7, 511, 0, 0, 0);
        fill_window(7, 248, 0, 100);
        send(rts_pkg::CMD_QUERY, 7, 248, 0);
        run_phase(60);
        configure(6, 2, 2, 230, 1, 1, 0);
        run_phase(100);
        while (requests_sent < 1350) begin
            configure($urandom_range(0, 40), $urandom_range(0, 3), $urandom_range(0, 3),
                      ($urandom_range(0, 4) == 0) ? $urandom_range(2, 40)
                                                  : $urandom_range(100, 256),
                      $urandom_range(0, 1), $urandom_range(0, 40), $urandom_range(0, 255));
            run_phase(200);
        end

        s_tvalid <= 0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (1000) @(posedge aclk);
        $display("covered %0d loads and %0d queries across %0d register settings",
                 sb.loads, sb.queries, settings_used);
        $display("query outcomes: %0d valid, %0d empty, %0d missing, %0d outside",
                 sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3]);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("status: fail");
        end
        $finish;
    end

endmodule
